@@ design/lbhm_pkg.sv @@
// Shared constants, types and helpers of the banked hash match finder.
`timescale 1ns / 1ps
package lbhm_pkg;

  localparam int unsigned WindowDepth = 4096;
  localparam int unsigned WinW        = $clog2(WindowDepth);
  localparam int unsigned MaxMatch    = 18;
  localparam int unsigned LaW         = $clog2(MaxMatch + 1);
  localparam int unsigned BankCount   = 8;
  localparam int unsigned BankW       = $clog2(BankCount);
  localparam int unsigned HashDepth   = 1024;
  localparam int unsigned KeyW        = $clog2(HashDepth);
  localparam int unsigned HashShift   = 5;
  localparam int unsigned MinSpan     = 2;
  localparam int unsigned HAddrW      = BankW + KeyW;
  localparam int unsigned ClrW        = HAddrW;

  typedef enum logic [1:0] {
    CMD_REPLACE   = 2'd0,
    CMD_LOOKAHEAD = 2'd1,
    CMD_FIND      = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_H_RD,
    ST_H_AC,
    ST_H_WR,
    ST_F_LA,
    ST_F_CRD,
    ST_F_CWT,
    ST_F_CMP,
    ST_OUT
  } state_e;

  // one hash step: ((key << 5) ^ byte) mod table size
  function automatic logic [KeyW-1:0] hash_step(logic [KeyW-1:0] key, logic [7:0] b);
    logic [KeyW+HashShift-1:0] sh;
    logic [KeyW+HashShift-1:0] mx;
    sh = {key, {HashShift{1'b0}}};
    mx = sh ^ (KeyW + HashShift)'(b);
    return mx[KeyW-1:0];
  endfunction

  function automatic logic [LaW-1:0] la_inc(logic [LaW-1:0] p);
    return (p == LaW'(MaxMatch - 1)) ? '0 : LaW'(p + 1'b1);
  endfunction

  function automatic logic [LaW-1:0] la_mod(logic [4:0] v);
    logic [5:0] w;
    w = {1'b0, v};
    return (w >= 6'(MaxMatch)) ? LaW'(w - 6'(MaxMatch)) : LaW'(w);
  endfunction

endpackage

@@ design/lbhm_if.sv @@
// Channel interfaces: command beats in, match result beats out.
`timescale 1ns / 1ps
interface lbhm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [11:0] window_index;
  logic [4:0] lookahead_index;
  logic [7:0] data_byte;
  modport source(output valid, command, window_index, lookahead_index, data_byte,
                 input ready);
  modport sink(input valid, command, window_index, lookahead_index, data_byte,
               output ready);
endinterface

interface lbhm_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  match_length;
  logic [11:0] match_offset;
  modport source(output valid, match_length, match_offset, input ready);
  modport sink(input valid, match_length, match_offset, output ready);
endinterface

@@ design/lzss_banked_hash_matcher.sv @@
// Top level of the LZSS match finder with an eight-bank hash table.
//
//   channel | dir | beat                                          | when
//   req_i   | in  | command, window_index, lookahead_index, byte  | valid & ready
//   rsp_o   | out | match_length, match_offset                    | valid & ready
//
// Reset clears lookahead flops at once, then sweeps window and hash banks one
// entry a cycle over all 8192 hash entries; meanwhile no command leaves the front queue.
// Replace: two window reads for the hash, then one bank write.
// Lookahead write: done from the idle state. Find: hashes the lookahead head, then for
// each bank reads the candidate and compares the run through the single window read port.
// A two-entry front queue keeps accepting beats while a result waits.
`timescale 1ns / 1ps
module lzss_banked_hash_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  lbhm_in_if.sink     req_i,
  lbhm_out_if.source  rsp_o
);

  lbhm_in_if q_if ();

  lbhm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_o  (q_if.source)
  );

  lbhm_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (q_if.sink),
    .rsp_o  (rsp_o)
  );

  // a result never exceeds the longest match
  a_len_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.match_length <= 5'(lbhm_pkg::MaxMatch)))
    else $error("match length out of range");

  // a result with no match carries a zero offset
  a_zero_off : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.match_length == 5'd0) |-> (rsp_o.match_offset == 12'd0))
    else $error("offset set without a match");

endmodule

@@ design/lbhm_front.sv @@
// Front queue: takes command beats, drops unused codes, buffers two items.
`timescale 1ns / 1ps
module lbhm_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  lbhm_in_if.sink      req_i,
  lbhm_in_if.source    cmd_o
);

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] window_index;
    logic [4:0]  lookahead_index;
    logic [7:0]  data_byte;
  } item_t;

  item_t       mem_q [2];
  logic        wp_q, wp_d, rp_q, rp_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        take, push, pop;

  assign req_i.ready = (cnt_q != 2'd2);
  assign take = req_i.valid && req_i.ready;
  // unused command code is swallowed here
  assign push = take && (req_i.command == lbhm_pkg::CMD_REPLACE ||
                         req_i.command == lbhm_pkg::CMD_LOOKAHEAD ||
                         req_i.command == lbhm_pkg::CMD_FIND);
  assign pop  = cmd_o.valid && cmd_o.ready;

  assign cmd_o.valid           = (cnt_q != 2'd0);
  assign cmd_o.command         = mem_q[rp_q].command;
  assign cmd_o.window_index    = mem_q[rp_q].window_index;
  assign cmd_o.lookahead_index = mem_q[rp_q].lookahead_index;
  assign cmd_o.data_byte       = mem_q[rp_q].data_byte;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = 2'(cnt_q + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= {req_i.command, req_i.window_index, req_i.lookahead_index,
                      req_i.data_byte};
    end
  end

endmodule

@@ design/lbhm_engine.sv @@
// Back end: window, lookahead and hash bank stores with the command sequencer.
`timescale 1ns / 1ps
module lbhm_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  lbhm_in_if.sink      cmd_i,
  lbhm_out_if.source   rsp_o
);

  localparam int unsigned WinW   = lbhm_pkg::WinW;
  localparam int unsigned LaW    = lbhm_pkg::LaW;
  localparam int unsigned KeyW   = lbhm_pkg::KeyW;
  localparam int unsigned BankW  = lbhm_pkg::BankW;
  localparam int unsigned HAddrW = lbhm_pkg::HAddrW;
  localparam int unsigned ClrW   = lbhm_pkg::ClrW;

  lbhm_pkg::state_e state_q, state_d;

  logic [7:0]        win_mem [lbhm_pkg::WindowDepth];
  logic [WinW-1:0]   hash_mem [2**HAddrW];
  logic [7:0]        la_q [lbhm_pkg::MaxMatch];

  logic              win_we, hash_we, la_we;
  logic [WinW-1:0]   win_waddr, win_raddr;
  logic [7:0]        win_wdata, win_rdata_q;
  logic [HAddrW-1:0] hash_waddr, hash_raddr;
  logic [WinW-1:0]   hash_wdata, hash_rdata_q;

  logic [ClrW-1:0]   clr_q, clr_d;
  logic [1:0]        k_q, k_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [WinW-1:0]   addr_q, addr_d;     // hash start or candidate
  logic [7:0]        byte_q, byte_d;
  logic [WinW-1:0]   widx_q, widx_d;
  logic [LaW-1:0]    lidx_q, lidx_d, ptr_q, ptr_d;
  logic [BankW-1:0]  bank_q, bank_d;
  logic [LaW-1:0]    run_q, run_d, best_q, best_d;
  logic [WinW-1:0]   off_q, off_d;

  logic [7:0]        la_rd;
  logic              eq, fin, full;
  logic [LaW-1:0]    run_n;

  assign la_rd = la_q[ptr_q];
  assign eq    = (win_rdata_q == la_rd);
  assign run_n = LaW'(run_q + 1'b1);
  assign full  = eq && (run_n == LaW'(lbhm_pkg::MaxMatch));
  assign fin   = !eq || full;

  assign cmd_i.ready        = (state_q == lbhm_pkg::ST_IDLE);
  assign rsp_o.valid        = (state_q == lbhm_pkg::ST_OUT);
  assign rsp_o.match_length = best_q;
  assign rsp_o.match_offset = off_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lbhm_pkg::ST_CLEAR: if (clr_q == '1) state_d = lbhm_pkg::ST_IDLE;
      lbhm_pkg::ST_IDLE: begin
        if (cmd_i.valid) begin
          if (cmd_i.command == lbhm_pkg::CMD_REPLACE) state_d = lbhm_pkg::ST_H_RD;
          else if (cmd_i.command == lbhm_pkg::CMD_FIND) state_d = lbhm_pkg::ST_F_LA;
        end
      end
      lbhm_pkg::ST_H_RD:  state_d = lbhm_pkg::ST_H_AC;
      lbhm_pkg::ST_H_AC:  state_d = (k_q == 2'd1) ? lbhm_pkg::ST_H_WR : lbhm_pkg::ST_H_RD;
      lbhm_pkg::ST_H_WR:  state_d = lbhm_pkg::ST_IDLE;
      lbhm_pkg::ST_F_LA:  if (k_q == 2'(lbhm_pkg::MinSpan)) state_d = lbhm_pkg::ST_F_CRD;
      lbhm_pkg::ST_F_CRD: state_d = lbhm_pkg::ST_F_CWT;
      lbhm_pkg::ST_F_CWT: state_d = lbhm_pkg::ST_F_CMP;
      lbhm_pkg::ST_F_CMP: begin
        if (fin) begin
          state_d = (full || bank_q == '1) ? lbhm_pkg::ST_OUT : lbhm_pkg::ST_F_CRD;
        end
      end
      lbhm_pkg::ST_OUT:   if (rsp_o.ready) state_d = lbhm_pkg::ST_IDLE;
      default:            state_d = lbhm_pkg::ST_IDLE;
    endcase
  end

  // datapath and store strobes
  always_comb begin
    clr_d  = clr_q;  k_d = k_q;  key_d = key_q;  addr_d = addr_q;
    byte_d = byte_q; widx_d = widx_q; lidx_d = lidx_q; ptr_d = ptr_q;
    bank_d = bank_q; run_d = run_q; best_d = best_q; off_d = off_q;
    win_we = 1'b0;  win_waddr = widx_q; win_wdata = byte_q; win_raddr = addr_q;
    hash_we = 1'b0; hash_waddr = {addr_q[BankW-1:0], key_q}; hash_wdata = addr_q;
    hash_raddr = {bank_q, key_q};
    la_we = 1'b0;
    unique case (state_q)
      lbhm_pkg::ST_CLEAR: begin
        win_we     = 1'b1;
        win_waddr  = clr_q[WinW-1:0];
        win_wdata  = '0;
        hash_we    = 1'b1;
        hash_waddr = clr_q[HAddrW-1:0];
        hash_wdata = '0;
        clr_d      = ClrW'(clr_q + 1'b1);
      end
      lbhm_pkg::ST_IDLE: begin
        k_d    = '0;
        key_d  = '0;
        byte_d = cmd_i.data_byte;
        widx_d = cmd_i.window_index;
        addr_d = WinW'(cmd_i.window_index - WinW'(lbhm_pkg::MinSpan));
        lidx_d = lbhm_pkg::la_mod(cmd_i.lookahead_index);
        ptr_d  = lbhm_pkg::la_mod(cmd_i.lookahead_index);
        bank_d = '0;
        best_d = '0;
        off_d  = '0;
        if (cmd_i.valid && cmd_i.command == lbhm_pkg::CMD_LOOKAHEAD) la_we = 1'b1;
      end
      lbhm_pkg::ST_H_RD: begin
        win_raddr = WinW'(addr_q + {{(WinW-2){1'b0}}, k_q});
      end
      lbhm_pkg::ST_H_AC: begin
        key_d = lbhm_pkg::hash_step(key_q, win_rdata_q);
        k_d   = 2'(k_q + 1'b1);
        // last byte of the string is the one being written now
        if (k_q == 2'd1) key_d = lbhm_pkg::hash_step(lbhm_pkg::hash_step(key_q,
                                  win_rdata_q), byte_q);
      end
      lbhm_pkg::ST_H_WR: begin
        win_we  = 1'b1;
        hash_we = 1'b1;
      end
      lbhm_pkg::ST_F_LA: begin
        key_d = lbhm_pkg::hash_step(key_q, la_rd);
        ptr_d = lbhm_pkg::la_inc(ptr_q);
        k_d   = 2'(k_q + 1'b1);
      end
      lbhm_pkg::ST_F_CRD: begin
        ptr_d = lidx_q;
        run_d = '0;
      end
      lbhm_pkg::ST_F_CWT: begin
        addr_d    = hash_rdata_q;
        win_raddr = hash_rdata_q;
      end
      lbhm_pkg::ST_F_CMP: begin
        win_raddr = WinW'(addr_q + WinW'(run_n));
        if (eq) begin
          run_d = run_n;
          ptr_d = lbhm_pkg::la_inc(ptr_q);
        end
        if (fin) begin
          if ((eq ? run_n : run_q) > best_q) begin
            best_d = eq ? run_n : run_q;
            off_d  = addr_q;
          end
          bank_d = BankW'(bank_q + 1'b1);
        end
      end
      lbhm_pkg::ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbhm_pkg::ST_CLEAR;
      clr_q   <= '0;
      k_q     <= '0;
      best_q  <= '0;
      off_q   <= '0;
      bank_q  <= '0;
      run_q   <= '0;
      ptr_q   <= '0;
      for (int i = 0; i < lbhm_pkg::MaxMatch; i++) la_q[i] <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      k_q     <= k_d;
      best_q  <= best_d;
      off_q   <= off_d;
      bank_q  <= bank_d;
      run_q   <= run_d;
      ptr_q   <= ptr_d;
      if (la_we) la_q[lbhm_pkg::la_mod(cmd_i.lookahead_index)] <= cmd_i.data_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    addr_q <= addr_d;
    byte_q <= byte_d;
    widx_q <= widx_d;
    lidx_q <= lidx_d;
  end

  always_ff @(posedge clk_i) begin
    if (win_we) win_mem[win_waddr] <= win_wdata;
    win_rdata_q <= win_mem[win_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (hash_we) hash_mem[hash_waddr] <= hash_wdata;
    hash_rdata_q <= hash_mem[hash_raddr];
  end

endmodule

@@ tb/sv/lbhm_checker.sv @@
// Match-finder checker: tracks window, lookahead and hash banks, predicts match results.
`timescale 1ns / 1ps
module lbhm_checker
  import lbhm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  lbhm_in_if.sink  req_i,
  lbhm_out_if.sink rsp_i,
  output int      fail_count_o,
  output int      pending_o
);

  typedef struct packed {
    logic [4:0]  len;
    logic [11:0] off;
  } match_t;

  logic [7:0]  win_mem [WindowDepth];
  logic [7:0]  la_mem  [MaxMatch];
  logic [11:0] bank_mem[BankCount][HashDepth];
  match_t      match_q[$];

  initial begin
    fail_count_o = 0;
    foreach (win_mem[i]) win_mem[i] = '0;
    foreach (la_mem[i]) la_mem[i] = '0;
    foreach (bank_mem[b, k]) bank_mem[b][k] = '0;
  end

  assign pending_o = match_q.size();

  function automatic int unsigned key_of_window(int unsigned start);
    int unsigned key;
    key = 0;
    for (int k = 0; k <= MinSpan; k++)
      key = ((key << HashShift) ^ win_mem[(start + k) % WindowDepth]) % HashDepth;
    return key;
  endfunction

  function automatic int unsigned key_of_lookahead(int unsigned head);
    int unsigned key;
    key = 0;
    for (int k = 0; k <= MinSpan; k++)
      key = ((key << HashShift) ^ la_mem[(head + k) % MaxMatch]) % HashDepth;
    return key;
  endfunction

  function automatic match_t longest_match(int unsigned head);
    int unsigned key, cand, run;
    match_t best;
    key = key_of_lookahead(head);
    best = '0;
    for (int b = 0; b < BankCount; b++) begin
      cand = bank_mem[b][key] % WindowDepth;
      if (win_mem[cand] == la_mem[head]) begin
        run = 1;
        while (run < MaxMatch &&
               win_mem[(cand + run) % WindowDepth] == la_mem[(head + run) % MaxMatch])
          run++;
        if (run > best.len) begin
          best.len = 5'(run);
          best.off = 12'(cand);
        end
        if (run >= MaxMatch) break;
      end
    end
    return best;
  endfunction

  always @(posedge clk_i) begin
    int unsigned widx, lidx, start;
    match_t got, want;
    if (rst_ni) begin
      if (req_i.valid && req_i.ready) begin
        widx = req_i.window_index % WindowDepth;
        lidx = req_i.lookahead_index % MaxMatch;
        if (req_i.command == CMD_REPLACE) begin
          start = (widx + WindowDepth - MinSpan) % WindowDepth;
          win_mem[widx] = req_i.data_byte;
          bank_mem[start % BankCount][key_of_window(start)] = 12'(start);
        end else if (req_i.command == CMD_LOOKAHEAD) begin
          la_mem[lidx] = req_i.data_byte;
        end else if (req_i.command == CMD_FIND) begin
          match_q.push_back(longest_match(lidx));
        end
      end
      if (rsp_i.valid && rsp_i.ready) begin
        got.len = rsp_i.match_length;
        got.off = rsp_i.match_offset;
        if (match_q.size() == 0) begin
          $display("%0t: unexpected result len=%0d off=%0d", $time, got.len, got.off);
          fail_count_o++;
        end else begin
          want = match_q.pop_front();
          if (got.len !== want.len) begin
            $display("%0t: match_length expected %0d actual %0d", $time, want.len, got.len);
            fail_count_o++;
          end
          if (got.off !== want.off) begin
            $display("%0t: match_offset expected %0d actual %0d", $time, want.off, got.off);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top: drives command beats and result back-pressure, gives the verdict.
`timescale 1ns / 1ps
module tb;
  import lbhm_pkg::*;

  localparam int ItemTarget = 1350;
  localparam int IdleLimit  = 50000;  // covers the whole clear sweep after reset
  localparam int HoldCycles = 400;

  logic clk_i;
  logic rst_ni;
  int   fail_count, pending;
  int   sent;
  int   send_idle_pct, recv_stall_pct;
  logic hold_go, hold_on;
  int   quiet_cycles;
  logic [7:0] win_shadow[WindowDepth];  // stimulus side copy, used to build matches

  lbhm_in_if  req_if();
  lbhm_out_if rsp_if();

  lzss_banked_hash_matcher uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  lbhm_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if.sink),
    .rsp_i       (rsp_if.sink),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off to fill the front queue
  always @(posedge clk_i) begin
    if (!rst_ni || hold_on)
      rsp_if.ready <= 1'b0;
    else
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    hold_on = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    for (int i = 0; i < HoldCycles; i++) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // one beat: optional idle gap, then hold valid until accepted
  task automatic send_beat(logic [1:0] cmd, logic [11:0] widx, logic [4:0] lidx,
                           logic [7:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid           <= 1'b1;
    req_if.command         <= cmd;
    req_if.window_index    <= widx;
    req_if.lookahead_index <= lidx;
    req_if.data_byte       <= data;
    if (cmd == CMD_REPLACE) win_shadow[widx] = data;
    do @(posedge clk_i); while (!req_if.ready);
    sent++;
  endtask

  // mostly tiny alphabet so hash hits and long runs are common
  function automatic logic [7:0] seq_byte();
    return ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3)) : 8'($urandom);
  endfunction

  // write a window run, copy part of it into the lookahead, then search
  task automatic copy_and_find(logic [11:0] base, int len, int head, bit corrupt);
    int cut;
    for (int i = 0; i < len; i++)
      send_beat(CMD_REPLACE, 12'(base + i), 5'($urandom), seq_byte());
    cut = $urandom_range(0, MaxMatch - 1);
    for (int i = 0; i < MaxMatch; i++)
      send_beat(CMD_LOOKAHEAD, 12'($urandom), 5'((head + i) % MaxMatch),
                (corrupt && i == cut) ? 8'($urandom) : win_shadow[12'(base + i)]);
    // head given either in range or as its out-of-range alias
    send_beat(CMD_FIND, 12'($urandom),
              (head < 14 && $urandom_range(0, 3) == 0) ? 5'(head + MaxMatch) : 5'(head),
              8'($urandom));
  endtask

  initial begin
    logic [1:0] cmd;
    sent = 0;
    hold_go = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    foreach (win_shadow[i]) win_shadow[i] = '0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.command = CMD_REPLACE;
    req_if.window_index = '0;
    req_if.lookahead_index = '0;
    req_if.data_byte = '0;
    rsp_if.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: search on the reset image (all-zero window and lookahead)
    send_beat(CMD_FIND, 12'd0, 5'd0, 8'd0);
    // unused code changes nothing
    send_beat(CMD_UNUSED, 12'hFFF, 5'd31, 8'hFF);
    // lookahead index past the end wraps, for write and search
    send_beat(CMD_LOOKAHEAD, 12'd0, 5'd31, 8'hFF);
    send_beat(CMD_FIND, 12'hFFF, 5'd31, 8'h00);
    // window wrap round the top: hashed start lands at 4094 and 4095
    send_beat(CMD_REPLACE, 12'd4094, 5'd0, 8'hFF);
    send_beat(CMD_REPLACE, 12'd4095, 5'd0, 8'h00);
    send_beat(CMD_REPLACE, 12'd0, 5'd0, 8'hFF);
    send_beat(CMD_REPLACE, 12'd1, 5'd0, 8'hAA);
    send_beat(CMD_LOOKAHEAD, 12'd0, 5'd17, 8'hFF);
    send_beat(CMD_LOOKAHEAD, 12'd0, 5'd18, 8'h00);
    send_beat(CMD_LOOKAHEAD, 12'd0, 5'd19, 8'hFF);
    send_beat(CMD_LOOKAHEAD, 12'd0, 5'd2, 8'hAA);
    send_beat(CMD_FIND, 12'd0, 5'd17, 8'h00);
    // head at the first lookahead slot, stale and reset bank entries
    send_beat(CMD_FIND, 12'd0, 5'd0, 8'h55);
    send_beat(CMD_LOOKAHEAD, 12'd0, 5'd0, 8'h55);
    send_beat(CMD_FIND, 12'd0, 5'd0, 8'h00);

    // random part, four idling phases; pressure burst in the first
    hold_go <= 1'b1;
    while (sent < ItemTarget) begin
      case (sent * 4 / ItemTarget)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      if ($urandom_range(0, 99) < 60) begin
        copy_and_find(12'($urandom), ($urandom_range(0, 4) == 0) ? 20 : $urandom_range(3, 8),
                      $urandom_range(0, MaxMatch - 1), $urandom_range(0, 2) == 0);
      end else begin
        cmd = 2'($urandom);
        send_beat(cmd, 12'($urandom), 5'($urandom), 8'($urandom));
      end
    end
    req_if.valid <= 1'b0;

    wait (pending == 0);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
